// ===== sv/gpc_pkg.sv =====
// gpc_pkg: shared widths, reset constants and interface structs for the
// grid peak centroid block. No dependencies; used by gpc_div and the top level.
package gpc_pkg;

    localparam int GRID_SIDE_DEF = 5;
    localparam int CHANNEL_W     = 5;
    localparam int ENERGY_W      = 20;
    localparam int POS_W         = 16;
    // signed position times zero-extended energy
    localparam int PROD_W        = POS_W + ENERGY_W + 1;
    // nine cells of a 3x3 cluster need four growth bits
    localparam int SE_W          = ENERGY_W + 4;
    localparam int SUM_W         = PROD_W + 4;

    localparam logic [ENERGY_W-1:0] THRESH_RESET = ENERGY_W'(3520);

    // one stored grid cell
    typedef struct packed {
        logic [ENERGY_W-1:0]     energy;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
    } cell_t;

    // divider request and response
    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] num;
        logic [SE_W-1:0]         den;
    } div_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [POS_W-1:0] quot;
    } div_rsp_t;

endpackage

// ===== sv/grid_peak_centroid.sv =====
// grid_peak_centroid: top level, grid store, peak scan, 3x3 cluster sums
// and centroid sequencing. Depends on gpc_pkg and gpc_div.
//
// Usage: a request (channel, energy, x_position, y_position, last) is taken
// on a clock edge where start is high and busy is low. Requests without last
// write one grid cell, or none for a channel beyond the grid. The request
// with last starts the event processing and busy stays high until the
// result is out. After last: a scan over all GRID_SIDE*GRID_SIDE cells
// through the single store read port, a threshold check, then for a
// passing peak nine cluster cells, each read, weighted by x and by y on
// the shared multiplier and accumulated, then two 41-step serial
// divisions (x, then y) and an output state.
// The result is on the output ports for exactly one cycle, flagged by
// result_valid; the receiver cannot stall, and busy is already low then.
// energy_threshold is written through cfg_valid / cfg_data (cfg_ready is
// high only while idle). Reset sets the threshold to THRESH_RESET (3520),
// empties the grid store and returns the sequencer to idle; the store is
// emptied again after each event.
module grid_peak_centroid #(
    parameter int GRID_SIDE = gpc_pkg::GRID_SIDE_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [gpc_pkg::CHANNEL_W-1:0]       channel,
    input  logic [gpc_pkg::ENERGY_W-1:0]        energy,
    input  logic signed [gpc_pkg::POS_W-1:0]    x_position,
    input  logic signed [gpc_pkg::POS_W-1:0]    y_position,
    input  logic                                last,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gpc_pkg::ENERGY_W-1:0]        cfg_data,
    output logic                                result_valid,
    output logic                                passed,
    output logic signed [gpc_pkg::POS_W-1:0]    x_centroid,
    output logic signed [gpc_pkg::POS_W-1:0]    y_centroid,
    output logic [gpc_pkg::CHANNEL_W-1:0]       peak_channel,
    output logic [gpc_pkg::ENERGY_W-1:0]        peak_energy
);
    import gpc_pkg::*;

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int IDX_W = $clog2(CELLS);
    localparam int RC_W  = $clog2(GRID_SIDE);

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_SCAN     = 13'b0000000000010,
        S_SCAN_END = 13'b0000000000100,
        S_CHECK    = 13'b0000000001000,
        S_RD       = 13'b0000000010000,
        S_MX       = 13'b0000000100000,
        S_MY       = 13'b0000001000000,
        S_ACC      = 13'b0000010000000,
        S_DX       = 13'b0000100000000,
        S_DXW      = 13'b0001000000000,
        S_DY       = 13'b0010000000000,
        S_DYW      = 13'b0100000000000,
        S_OUT      = 13'b1000000000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [RC_W-1:0]         srow_reg, srow_next;
    logic [RC_W-1:0]         scol_reg, scol_next;
    logic                    cmp_en_reg, cmp_en_next;
    logic [ENERGY_W-1:0]     best_e_reg, best_e_next;
    logic [IDX_W-1:0]        best_idx_reg, best_idx_next;
    logic [RC_W-1:0]         best_row_reg, best_row_next;
    logic [RC_W-1:0]         best_col_reg, best_col_next;
    logic [1:0]              dr_reg, dr_next;
    logic [1:0]              dc_reg, dc_next;
    logic [SE_W-1:0]         se_reg, se_next;
    logic signed [SUM_W-1:0] sx_reg, sx_next;
    logic signed [SUM_W-1:0] sy_reg, sy_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [POS_W-1:0] xq_reg, xq_next;
    logic signed [POS_W-1:0] yq_reg, yq_next;
    logic [ENERGY_W-1:0]     thr_reg, thr_next;
    logic [CELLS-1:0]        valid_reg, valid_next;
    logic                    rv_reg, rv_next;
    logic                    passed_reg, passed_next;
    logic signed [POS_W-1:0] xc_reg, xc_next;
    logic signed [POS_W-1:0] yc_reg, yc_next;
    logic [IDX_W-1:0]        pch_reg, pch_next;
    logic [ENERGY_W-1:0]     pe_reg, pe_next;

    // grid store and its read pipeline
    cell_t                   mem [CELLS];
    cell_t                   rd_cell;
    logic                    rd_valid_reg;
    logic [IDX_W-1:0]        pipe_idx_reg;
    logic [RC_W-1:0]         pipe_row_reg;
    logic [RC_W-1:0]         pipe_col_reg;

    logic                    accept;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    cell_t                   wr_cell;
    logic                    rd_en;
    logic                    rd_ok;
    logic [IDX_W-1:0]        rd_addr;
    logic [ENERGY_W-1:0]     eff_e;
    logic signed [RC_W+1:0]  r_s;
    logic signed [RC_W+1:0]  c_s;
    logic                    in_grid;
    logic [IDX_W-1:0]        k_addr;
    logic signed [POS_W-1:0] mul_a;
    logic signed [ENERGY_W:0] mul_b;
    div_req_t                div_req;
    div_rsp_t                div_rsp;

    gpc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // request accept and store write
    always_comb
    begin
        accept        = start && (state_reg == S_IDLE);
        wr_en         = accept && (32'(channel) < 32'(CELLS));
        wr_addr       = IDX_W'(channel);
        wr_cell.energy = energy;
        wr_cell.x     = x_position;
        wr_cell.y     = y_position;
    end

    // cluster neighbor address, clipped at the grid edge
    always_comb
    begin
        r_s    = $signed({2'b00, best_row_reg}) + $signed({{RC_W{1'b0}}, dr_reg})
                 - (RC_W+2)'(1);
        c_s    = $signed({2'b00, best_col_reg}) + $signed({{RC_W{1'b0}}, dc_reg})
                 - (RC_W+2)'(1);
        in_grid = !r_s[RC_W+1] && (r_s < (RC_W+2)'(GRID_SIDE))
                  && !c_s[RC_W+1] && (c_s < (RC_W+2)'(GRID_SIDE));
        k_addr = IDX_W'(32'(r_s[RC_W-1:0]) * GRID_SIDE + 32'(c_s[RC_W-1:0]));
    end

    // cell energy, empty cells read as zero
    assign eff_e = rd_valid_reg ? rd_cell.energy : '0;

    // shared multiplier operands, empty cells contribute zero
    always_comb
    begin
        if (!rd_valid_reg)
        begin
            mul_a = '0;
        end
        else
        begin
            mul_a = (state_reg == S_MY) ? rd_cell.y : rd_cell.x;
        end
        mul_b = $signed({1'b0, eff_e});
    end

    // divider request
    always_comb
    begin
        div_req.start = (state_reg == S_DX) || (state_reg == S_DY);
        div_req.num   = (state_reg == S_DY) ? sy_reg : sx_reg;
        div_req.den   = se_reg;
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        srow_next     = srow_reg;
        scol_next     = scol_reg;
        cmp_en_next   = 1'b0;
        best_e_next   = best_e_reg;
        best_idx_next = best_idx_reg;
        best_row_next = best_row_reg;
        best_col_next = best_col_reg;
        dr_next       = dr_reg;
        dc_next       = dc_reg;
        se_next       = se_reg;
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        prod_next     = prod_reg;
        xq_next       = xq_reg;
        yq_next       = yq_reg;
        valid_next    = valid_reg;
        rv_next       = 1'b0;
        passed_next   = passed_reg;
        xc_next       = xc_reg;
        yc_next       = yc_reg;
        pch_next      = pch_reg;
        pe_next       = pe_reg;
        rd_en         = 1'b0;
        rd_ok         = 1'b0;
        rd_addr       = idx_reg;

        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end

        // running peak compare, first highest wins
        if (cmp_en_reg && (eff_e > best_e_reg))
        begin
            best_e_next   = eff_e;
            best_idx_next = pipe_idx_reg;
            best_row_next = pipe_row_reg;
            best_col_next = pipe_col_reg;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && last)
                begin
                    idx_next      = '0;
                    srow_next     = '0;
                    scol_next     = '0;
                    best_e_next   = '0;
                    best_idx_next = '0;
                    best_row_next = '0;
                    best_col_next = '0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                rd_en       = 1'b1;
                rd_ok       = 1'b1;
                rd_addr     = idx_reg;
                cmp_en_next = 1'b1;
                idx_next    = idx_reg + IDX_W'(1);
                if (scol_reg == RC_W'(GRID_SIDE - 1))
                begin
                    scol_next = '0;
                    srow_next = srow_reg + RC_W'(1);
                end
                else
                begin
                    scol_next = scol_reg + RC_W'(1);
                end
                if (idx_reg == IDX_W'(CELLS - 1))
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                se_next = '0;
                sx_next = '0;
                sy_next = '0;
                dr_next = '0;
                dc_next = '0;
                if (best_e_reg > thr_reg)
                begin
                    state_next = S_RD;
                end
                else
                begin
                    passed_next = 1'b0;
                    xq_next     = '0;
                    yq_next     = '0;
                    state_next  = S_OUT;
                end
            end
            S_RD:
            begin
                rd_en      = 1'b1;
                rd_ok      = in_grid;
                rd_addr    = k_addr;
                state_next = S_MX;
            end
            S_MX:
            begin
                prod_next  = mul_a * mul_b;
                se_next    = se_reg + SE_W'(eff_e);
                state_next = S_MY;
            end
            S_MY:
            begin
                sx_next    = sx_reg + SUM_W'(prod_reg);
                prod_next  = mul_a * mul_b;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                sy_next = sy_reg + SUM_W'(prod_reg);
                if (dc_reg == 2'd2)
                begin
                    dc_next = '0;
                    dr_next = dr_reg + 2'd1;
                end
                else
                begin
                    dc_next = dc_reg + 2'd1;
                end
                if ((dr_reg == 2'd2) && (dc_reg == 2'd2))
                begin
                    state_next = S_DX;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_DX:
            begin
                state_next = S_DXW;
            end
            S_DXW:
            begin
                if (div_rsp.done)
                begin
                    xq_next    = div_rsp.quot;
                    state_next = S_DY;
                end
            end
            S_DY:
            begin
                state_next = S_DYW;
            end
            S_DYW:
            begin
                if (div_rsp.done)
                begin
                    yq_next     = div_rsp.quot;
                    passed_next = 1'b1;
                    state_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                rv_next    = 1'b1;
                xc_next    = (se_reg == '0) ? '0 : xq_reg;
                yc_next    = (se_reg == '0) ? '0 : yq_reg;
                pch_next   = best_idx_reg;
                pe_next    = best_e_reg;
                valid_next = '0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // threshold register, written only while idle
    always_comb
    begin
        thr_next = thr_reg;
        if (cfg_valid && cfg_ready)
        begin
            thr_next = cfg_data;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cmp_en_reg   <= 1'b0;
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rv_reg       <= 1'b0;
            thr_reg      <= THRESH_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            cmp_en_reg   <= cmp_en_next;
            valid_reg    <= valid_next;
            rv_reg       <= rv_next;
            thr_reg      <= thr_next;
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr] && rd_ok;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        srow_reg     <= srow_next;
        scol_reg     <= scol_next;
        best_e_reg   <= best_e_next;
        best_idx_reg <= best_idx_next;
        best_row_reg <= best_row_next;
        best_col_reg <= best_col_next;
        dr_reg       <= dr_next;
        dc_reg       <= dc_next;
        se_reg       <= se_next;
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        prod_reg     <= prod_next;
        xq_reg       <= xq_next;
        yq_reg       <= yq_next;
        passed_reg   <= passed_next;
        xc_reg       <= xc_next;
        yc_reg       <= yc_next;
        pch_reg      <= pch_next;
        pe_reg       <= pe_next;
    end

    // grid store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_cell;
        end
        if (rd_en)
        begin
            rd_cell      <= mem[rd_addr];
            pipe_idx_reg <= rd_addr;
            pipe_row_reg <= srow_reg;
            pipe_col_reg <= scol_reg;
        end
    end

    // ports
    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = (state_reg == S_IDLE);
    assign result_valid = rv_reg;
    assign passed       = passed_reg;
    assign x_centroid   = xc_reg;
    assign y_centroid   = yc_reg;
    assign peak_channel = CHANNEL_W'(pch_reg);
    assign peak_energy  = pe_reg;

endmodule

// ===== sv/gpc_div.sv =====
// gpc_div: serial restoring divider, one quotient bit per cycle, quotient
// truncated toward zero and returned as its low 16 bits. Depends on gpc_pkg.
module gpc_div (
    input  logic               clk,
    input  logic               rst_n,
    input  gpc_pkg::div_req_t  req,
    output gpc_pkg::div_rsp_t  rsp
);
    import gpc_pkg::*;

    localparam int CNT_W = $clog2(SUM_W);

    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic                 neg_reg, neg_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [SE_W-1:0]      rem_reg, rem_next;
    logic [SE_W-1:0]      den_reg, den_next;
    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [SE_W:0]        trial;
    logic                 ge;
    logic [POS_W-1:0]     qlow;

    // one restoring step
    always_comb
    begin
        trial     = {rem_reg, quo_reg[SUM_W-1]};
        ge        = trial >= {1'b0, den_reg};
        run_next  = run_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            run_next = 1'b1;
            neg_next = req.num[SUM_W-1];
            quo_next = req.num[SUM_W-1] ? SUM_W'(-req.num) : SUM_W'(req.num);
            rem_next = '0;
            den_next = req.den;
            cnt_next = '0;
        end
        else if (run_reg)
        begin
            rem_next = ge ? SE_W'(trial - {1'b0, den_reg}) : SE_W'(trial);
            quo_next = {quo_reg[SUM_W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(SUM_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    // restore sign
    always_comb
    begin
        qlow     = quo_reg[POS_W-1:0];
        rsp.done = done_reg;
        rsp.quot = neg_reg ? $signed(-qlow) : $signed(qlow);
    end

endmodule

// ===== dv/grid_peak_centroid_test.sv =====
`timescale 1ns / 1ps
// grid_peak_centroid_test: self-checking bench for the grid peak centroid block
// scoreboard class predicts one result per event; plain tasks drive requests and
// threshold writes. Depends on gpc_pkg and grid_peak_centroid.
module grid_peak_centroid_test;

    import gpc_pkg::*;

    localparam int GRID_SIDE  = 5;
    localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
    localparam int CYCLE_LIMIT = 1_000_000;
    // worst event: full scan, nine cluster cells and two divisions
    localparam int EVENT_LATENCY = 160;

    typedef struct {
        logic                    passed;
        logic signed [POS_W-1:0] x_centroid;
        logic signed [POS_W-1:0] y_centroid;
        logic [CHANNEL_W-1:0]    peak_channel;
        logic [ENERGY_W-1:0]     peak_energy;
    } cluster_result_t;

    // grid store, threshold and the queue of predicted event results
    class centroid_scoreboard;
        cell_t               grid[GRID_CELLS];
        logic [ENERGY_W-1:0] threshold;
        cluster_result_t     result_q[$];
        int                  mismatch_count;

        function new();
            clear_grid();
            threshold      = THRESH_RESET;
            mismatch_count = 0;
        endfunction

        function void clear_grid();
            foreach (grid[i])
                grid[i] = '0;
        endfunction

        function int pending();
            return result_q.size();
        endfunction

        function void set_threshold(logic [ENERGY_W-1:0] value);
            threshold = value;
        endfunction

        // load one cell; on the closing request find the peak and its cluster
        function void note_request(logic [CHANNEL_W-1:0] ch, logic [ENERGY_W-1:0] e,
                                   logic signed [POS_W-1:0] xp,
                                   logic signed [POS_W-1:0] yp, logic closing);
            cluster_result_t res;
            int     row;
            int     col;
            int     r;
            int     c;
            int     k;
            longint sum_e;
            longint sum_x;
            longint sum_y;
            if (ch < GRID_CELLS)
                grid[ch] = '{energy: e, x: xp, y: yp};
            if (!closing)
                return;
            // first highest energy in channel order wins
            res.peak_energy  = grid[0].energy;
            res.peak_channel = '0;
            for (int i = 1; i < GRID_CELLS; i++)
            begin
                if (grid[i].energy > res.peak_energy)
                begin
                    res.peak_energy  = grid[i].energy;
                    res.peak_channel = CHANNEL_W'(i);
                end
            end
            res.passed = res.peak_energy > threshold;
            sum_e = 0;
            sum_x = 0;
            sum_y = 0;
            if (res.passed)
            begin
                row = int'(res.peak_channel) / GRID_SIDE;
                col = int'(res.peak_channel) % GRID_SIDE;
                for (int dr = -1; dr <= 1; dr++)
                begin
                    for (int dc = -1; dc <= 1; dc++)
                    begin
                        r = row + dr;
                        c = col + dc;
                        if (r >= 0 && r < GRID_SIDE && c >= 0 && c < GRID_SIDE)
                        begin
                            k = r * GRID_SIDE + c;
                            sum_e += longint'(grid[k].energy);
                            sum_x += longint'($signed(grid[k].x)) * longint'(grid[k].energy);
                            sum_y += longint'($signed(grid[k].y)) * longint'(grid[k].energy);
                        end
                    end
                end
            end
            // truncating division, zero weight gives zero
            res.x_centroid = (res.passed && sum_e > 0) ? POS_W'(sum_x / sum_e) : '0;
            res.y_centroid = (res.passed && sum_e > 0) ? POS_W'(sum_y / sum_e) : '0;
            result_q.push_back(res);
            clear_grid();
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got)
            begin
                $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_result(cluster_result_t got);
            cluster_result_t want;
            if (result_q.size() == 0)
            begin
                $display("%0t: result with none expected, actual peak %0d energy %0d",
                         $time, got.peak_channel, got.peak_energy);
                mismatch_count++;
                return;
            end
            want = result_q.pop_front();
            compare_field("passed", want.passed, got.passed);
            compare_field("x_centroid", want.x_centroid, got.x_centroid);
            compare_field("y_centroid", want.y_centroid, got.y_centroid);
            compare_field("peak_channel", want.peak_channel, got.peak_channel);
            compare_field("peak_energy", want.peak_energy, got.peak_energy);
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [CHANNEL_W-1:0]    channel;
    logic [ENERGY_W-1:0]     energy;
    logic signed [POS_W-1:0] x_position;
    logic signed [POS_W-1:0] y_position;
    logic                    last;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [ENERGY_W-1:0]     cfg_data;
    logic                    result_valid;
    logic                    passed;
    logic signed [POS_W-1:0] x_centroid;
    logic signed [POS_W-1:0] y_centroid;
    logic [CHANNEL_W-1:0]    peak_channel;
    logic [ENERGY_W-1:0]     peak_energy;

    centroid_scoreboard  sb;
    logic [ENERGY_W-1:0] thr_now;
    int                  burst_left;
    int                  cycle_count;

    grid_peak_centroid #(
        .GRID_SIDE(GRID_SIDE)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .channel      (channel),
        .energy       (energy),
        .x_position   (x_position),
        .y_position   (y_position),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .passed       (passed),
        .x_centroid   (x_centroid),
        .y_centroid   (y_centroid),
        .peak_channel (peak_channel),
        .peak_energy  (peak_energy)
    );

    // 12 ns clock
    initial
        clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // monitor: results first, so an event closing on the same edge queues behind
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                sb.check_result('{passed, x_centroid, y_centroid, peak_channel, peak_energy});
            if (start && !busy)
                sb.note_request(channel, energy, x_position, y_position, last);
            if (cfg_valid && cfg_ready)
                sb.set_threshold(cfg_data);
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("grid_peak_centroid: mismatch");
        $finish;
    end

    // one request, with a random gap whenever a burst runs out
    task automatic send_item(input logic [CHANNEL_W-1:0] ch, input logic [ENERGY_W-1:0] e,
                             input logic signed [POS_W-1:0] xp,
                             input logic signed [POS_W-1:0] yp, input logic closing);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        start      <= 1'b1;
        channel    <= ch;
        energy     <= e;
        x_position <= xp;
        y_position <= yp;
        last       <= closing;
        do
            @(posedge clk);
        while (busy);
    endtask

    // threshold write once the block has drained
    task automatic load_threshold(input logic [ENERGY_W-1:0] value);
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        thr_now = value;
    endtask

    function automatic logic signed [POS_W-1:0] pick_position();
        case ($urandom_range(0, 3))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            default: return POS_W'($urandom);
        endcase
    endfunction

    // energies spread over zero, small, near threshold, full range and ties
    function automatic logic [ENERGY_W-1:0] pick_energy(bit quiet);
        longint near;
        if (quiet)
            return ENERGY_W'($urandom_range(0, thr_now));
        case ($urandom_range(0, 9))
            0, 1: return '0;
            2, 3: return ENERGY_W'($urandom_range(0, 4095));
            4, 5:
            begin
                near = longint'(thr_now) + $urandom_range(0, 4) - 2;
                if (near < 0)
                    near = 0;
                if (near > 20'hFFFFF)
                    near = 20'hFFFFF;
                return ENERGY_W'(near);
            end
            6, 7: return ENERGY_W'($urandom);
            8: return 20'hFFFFF;
            default: return ($urandom_range(0, 1) == 0) ? ENERGY_W'(777) : thr_now + 1'b1;
        endcase
    endfunction

    // whole events of random length, a few with stray channels or low energies
    task automatic run_events(input int n_items);
        int  sent;
        int  len;
        bit  quiet;
        logic [CHANNEL_W-1:0] ch;
        sent = 0;
        while (sent < n_items)
        begin
            len   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 25);
            quiet = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < len; i++)
            begin
                ch = ($urandom_range(0, 15) == 0) ? CHANNEL_W'($urandom_range(25, 31))
                                                  : CHANNEL_W'($urandom_range(0, 24));
                send_item(ch, pick_energy(quiet), pick_position(), pick_position(),
                          i == len - 1);
            end
            sent += len;
        end
    endtask

    // stimulus
    initial
    begin
        int cluster_cells[9];
        sb         = new();
        rst_n      = 1'b0;
        start      = 1'b0;
        channel    = '0;
        energy     = '0;
        x_position = '0;
        y_position = '0;
        last       = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        thr_now    = THRESH_RESET;
        burst_left = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty event: absent channels read as zero
        send_item(0, 0, 0, 0, 1'b1);
        // channel outside the grid is dropped, last still closes the event
        send_item(31, 20'hFFFFF, 16'sh7FFF, 16'sh7FFF, 1'b1);
        // corner peak, cluster clipped at the grid edge
        send_item(18, 20'h12345, 16'sh8000, 16'sh7FFF, 1'b0);
        send_item(19, 20'h00010, 16'sh7FFF, 16'sh8000, 1'b0);
        send_item(23, 20'h00001, 16'sh0000, 16'sh0001, 1'b0);
        send_item(24, 20'hFFFFF, 16'sh7FFF, 16'sh8000, 1'b1);
        // tie on the peak and a rewritten channel
        send_item(12, 5000, 100, -100, 1'b0);
        send_item(7, 9000, -300, 300, 1'b0);
        send_item(7, 5000, -7, 9, 1'b0);
        send_item(13, 5000, 250, 40, 1'b1);
        // peak equal to the threshold fails
        send_item(6, THRESH_RESET, 123, 456, 1'b1);
        // one step above the threshold passes
        send_item(0, 3521, 16'sh8000, 16'sh7FFF, 1'b0);
        send_item(25, 1, 1, 1, 1'b0);
        send_item(1, 1, 16'sh7FFF, 16'sh8000, 1'b1);
        // full 3x3 around the center, negative positions
        cluster_cells = '{6, 7, 8, 11, 12, 13, 16, 17, 18};
        foreach (cluster_cells[i])
            send_item(CHANNEL_W'(cluster_cells[i]),
                      (cluster_cells[i] == 12) ? 20'hFFFFE : ENERGY_W'($urandom_range(1, 20'h7FFFF)),
                      -POS_W'($urandom_range(1, 32768)), -POS_W'($urandom_range(1, 32768)),
                      i == 8);

        // threshold phases, extremes first
        load_threshold('0);
        run_events(300);
        load_threshold(20'hFFFFF);
        run_events(150);
        load_threshold(ENERGY_W'($urandom));
        run_events(300);
        load_threshold(1);
        run_events(200);
        load_threshold(ENERGY_W'($urandom_range(0, 8000)));
        run_events(300);
        load_threshold(THRESH_RESET);
        run_events(200);

        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (EVENT_LATENCY) @(posedge clk);
        if (sb.mismatch_count == 0)
            $display("grid_peak_centroid: match");
        else
            $display("grid_peak_centroid: mismatch");
        $finish;
    end

endmodule
